// ----- hdl/bol_pkg.sv -----
`default_nettype none
package bol_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = 5;
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [3:0] {
    ACT_ADD_BACK  = 4'd0,
    ACT_ADD_FRONT = 4'd1,
    ACT_ADD_AT    = 4'd2,
    ACT_REM_BACK  = 4'd3,
    ACT_REM_FRONT = 4'd4,
    ACT_REM_AT    = 4'd5,
    ACT_CONTAINS  = 4'd6,
    ACT_GET_AT    = 4'd7,
    ACT_INDEX_OF  = 4'd8,
    ACT_LENGTH    = 4'd9,
    ACT_CLEAR     = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_op_t;

  typedef struct packed {
    shift_op_t              op;
    logic [POS_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/bounded_ordered_list.sv -----
// Bounded ordered list of up to 16 signed 32-bit values.
//
// Requests arrive on the in_ channel (action, value, index) with a
// valid/ready handshake; every request yields exactly one word on the out_
// channel carrying status, result value, position, found flag and the list
// length after the operation.
//
// The list lives in a row of cells, one entry per cell. An insert makes every
// cell above the insert point take its lower neighbor, a removal makes every
// cell at or above the removal point take its upper neighbor, and a search
// compares all cells against the value at once. Each request therefore
// finishes in the cycle it is accepted: its registered result appears in the
// next cycle, and one request is taken per cycle while the receiver keeps up.
//
// When the receiver stalls, the result is held in the output register and
// in_ready drops until it is taken; the list does not change meanwhile.
// Reset empties the list and clears the output valid; entry contents are
// not cleared, since nothing below the length is ever read before written.
`default_nettype none
module bounded_ordered_list (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [3:0]  in_action,
  input  wire  signed [31:0] in_value,
  input  wire         [4:0]  in_index,
  output logic               out_valid,
  input  wire                out_ready,
  output logic        [2:0]  out_status,
  output logic signed [31:0] out_result_value,
  output logic        [3:0]  out_position,
  output logic               out_found,
  output logic        [4:0]  out_length
);
  import bol_pkg::*;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  status_t                status_r;
  status_t                status_nxt;
  logic [31:0]            rv_r;
  logic [31:0]            rv_nxt;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;
  logic                   found_r;
  logic                   found_nxt;

  logic                   fire;
  cell_ctl_t              ctl;
  logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  logic [CAPACITY-1:0]    hit;
  logic                   any_hit;
  logic [POS_W-1:0]       first_hit;
  logic [POS_W-1:0]       rd_idx;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   full;
  logic                   empty;
  logic                   idx_gt_cnt;
  logic                   idx_ge_cnt;
  action_t                act;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign act      = action_t'(in_action);

  assign full       = (count_r == CNT_W'(CAPACITY));
  assign empty      = (count_r == '0);
  assign idx_gt_cnt = (CMP_W'(in_index) > CMP_W'(count_r));
  assign idx_ge_cnt = (CMP_W'(in_index) >= CMP_W'(count_r));

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_q;
      logic [VALUE_WIDTH-1:0] right_q;
      if (gi == 0) begin : g_first
        assign left_q = '0;
      end else begin : g_left
        assign left_q = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_q = '0;
      end else begin : g_right
        assign right_q = cell_q[gi+1];
      end
      bol_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .cell_idx (POS_W'(gi)),
        .left_q   (left_q),
        .right_q  (right_q),
        .q        (cell_q[gi]),
        .match    (cell_match[gi])
      );
      assign hit[gi] = cell_match[gi] && (CNT_W'(gi) < count_r);
    end
  endgenerate

  assign any_hit = |hit;

  always_comb begin
    first_hit = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_hit = POS_W'(i);
      end
    end
  end

  assign rd_idx  = (act == ACT_REM_BACK)  ? POS_W'(count_r - 1'b1) :
                   (act == ACT_REM_FRONT) ? '0 : POS_W'(in_index);
  assign rd_data = cell_q[rd_idx];

  always_comb begin
    ctl.op     = SH_HOLD;
    ctl.pos    = '0;
    ctl.value  = VALUE_WIDTH'(in_value);
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rv_nxt     = '0;
    pos_nxt    = '0;
    found_nxt  = 1'b0;
    unique case (act)
      ACT_ADD_BACK, ACT_ADD_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.op    = SH_INSERT;
          ctl.pos   = (act == ACT_ADD_BACK) ? POS_W'(count_r) : '0;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_ADD_AT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (idx_gt_cnt) begin
          status_nxt = ST_BADIDX;
        end else begin
          ctl.op    = SH_INSERT;
          ctl.pos   = POS_W'(in_index);
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REM_BACK, ACT_REM_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.op    = SH_REMOVE;
          ctl.pos   = rd_idx;
          rv_nxt    = 32'(rd_data);
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_REM_AT, ACT_GET_AT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (idx_ge_cnt) begin
          status_nxt = ST_BADIDX;
        end else begin
          rv_nxt = 32'(rd_data);
          if (act == ACT_REM_AT) begin
            ctl.op    = SH_REMOVE;
            ctl.pos   = rd_idx;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      ACT_CONTAINS: begin
        found_nxt = any_hit;
      end
      ACT_INDEX_OF: begin
        if (any_hit) begin
          pos_nxt   = first_hit;
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (!fire) begin
      ctl.op    = SH_HOLD;
      count_nxt = count_r;
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      rv_r     <= rv_nxt;
      pos_r    <= pos_nxt;
      found_r  <= found_nxt;
    end
  end

  logic [CNT_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      len_r <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_value = signed'(rv_r);
  assign out_position     = 4'(pos_r);
  assign out_found        = found_r;
  assign out_length       = 5'(len_r);

endmodule
`default_nettype wire

// ----- hdl/bol_cell.sv -----
`default_nettype none
module bol_cell (
  input  wire                              clk,
  input  wire  bol_pkg::cell_ctl_t         ctl,
  input  wire  [bol_pkg::POS_W-1:0]        cell_idx,
  input  wire  [bol_pkg::VALUE_WIDTH-1:0]  left_q,
  input  wire  [bol_pkg::VALUE_WIDTH-1:0]  right_q,
  output logic [bol_pkg::VALUE_WIDTH-1:0]  q,
  output logic                             match
);
  import bol_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      SH_INSERT: begin
        if (cell_idx == ctl.pos) begin
          entry_nxt = ctl.value;
        end else if (cell_idx > ctl.pos) begin
          entry_nxt = left_q;
        end
      end
      SH_REMOVE: begin
        if (cell_idx >= ctl.pos) begin
          entry_nxt = right_q;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q     = entry_r;
  assign match = (entry_r == ctl.value);

endmodule
`default_nettype wire

// ----- hdl/bol_checker.sv -----
`default_nettype none
module bol_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire        [2:0]  out_status,
  input wire signed [31:0] out_result_value,
  input wire        [3:0]  out_position,
  input wire               out_found,
  input wire        [4:0]  out_length
);
  import bol_pkg::*;

  // A stalled result word holds its value until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_value) && $stable(out_length))
    else $error("stalled result word changed");

  // A full status only comes back from a list that is at capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_length == 5'(CAPACITY))
    else $error("full status with list below capacity");

  // A found value is always reported with an ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found flag with non-ok status");

  // A missing value reports no position and no found flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOTFOUND |-> !out_found && out_position == '0)
    else $error("not found status with position or found flag");

  // While a result waits, no new request can be taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result word stalled");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_result_value (out_result_value),
  .out_position     (out_position),
  .out_found        (out_found),
  .out_length       (out_length)
);
`default_nettype wire
